@@ sv/atc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atc_pkg
// Shared codes, byte constants and the queue item type of the text console.
// ----------------------------------------------------------------------------
package atc_pkg;

  // request types on the input channel
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_BLINK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // output commands
  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 1'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;

  // byte codes
  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_ESC        = 8'h1B;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_M          = 8'h6D;

  // select graphic rendition numbers
  localparam int SGR_FG_LO   = 30;
  localparam int SGR_FG_HI   = 37;
  localparam int SGR_BG_LO   = 40;
  localparam int SGR_BG_HI   = 47;
  localparam int ESC_NUM_MAX = 1023;
  localparam int ESC_NUM_W   = 10;

  localparam logic [2:0] FORE_RESET = 3'd7;
  localparam logic [2:0] BACK_RESET = 3'd0;

  localparam int TAB_STOP        = 4;
  localparam int BLINK_W         = 6;
  localparam int BLINK_TICKS_DEF = 50;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [2:0] {
    OP_TEXT,
    OP_ESC,
    OP_LF,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_BLINK,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] code;
  } op_t;

endpackage
`default_nettype wire

@@ sv/atc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atc_req_if / atc_cmd_if
// Valid/ready channels for console requests and cell commands.
// ----------------------------------------------------------------------------
interface atc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source(output valid, req_type, char_code, input ready);
  modport sink(input valid, req_type, char_code, output ready);
endinterface

interface atc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] glyph;
  logic [7:0] cell_col;
  logic [7:0] cell_row;
  logic [2:0] fore_index;
  logic [2:0] back_index;
  logic       last_of_run;

  modport source(output valid, command, glyph, cell_col, cell_row, fore_index,
                 back_index, last_of_run, input ready);
  modport sink(input valid, command, glyph, cell_col, cell_row, fore_index,
               back_index, last_of_run, output ready);
endinterface
`default_nettype wire

@@ sv/atc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atc_front
// Accepts requests, classifies bytes and queues ops for the executor.
// ----------------------------------------------------------------------------
module atc_front (
  input  wire logic       clk,
  input  wire logic       rst,
  atc_req_if.sink         req_chan,
  output atc_pkg::op_t    q_op,
  output logic            q_valid,
  input  wire logic       q_pop
);
  import atc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  op_t  in_op;
  logic accept;
  logic push;
  logic pop;

  always_comb begin
    in_op.code = req_chan.char_code;
    unique case (req_chan.req_type)
      REQ_CHAR: begin
        unique case (req_chan.char_code)
          CH_ESC:  in_op.kind = OP_ESC;
          CH_LF:   in_op.kind = OP_LF;
          CH_CR:   in_op.kind = OP_CR;
          CH_BS:   in_op.kind = OP_BS;
          CH_TAB:  in_op.kind = OP_TAB;
          default: in_op.kind = OP_TEXT;
        endcase
      end
      REQ_BLINK: in_op.kind = OP_BLINK;
      REQ_CLEAR: in_op.kind = OP_CLEAR;
      REQ_NONE:  in_op.kind = OP_TEXT;
    endcase
  end

  assign req_chan.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign accept         = req_chan.valid && req_chan.ready;
  // drop the unused request type here
  assign push           = accept && (req_chan.req_type != REQ_NONE);
  assign pop            = q_pop && q_valid;

  assign q_valid = (count != '0);
  assign q_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_op;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_push_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count missed a push");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

@@ sv/atc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atc_back
// Executes queued ops: cursor, colors, escape parser, blink, and emits cell
// commands through a registered output stage, one per cycle unless it stalls.
// ----------------------------------------------------------------------------
module atc_back #(
  parameter int BLINK_TICKS = atc_pkg::BLINK_TICKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [atc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [atc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire atc_pkg::op_t                       q_op,
  input  wire logic                               q_valid,
  output logic                                    q_pop,
  atc_cmd_if.source                               cmd_chan
);
  import atc_pkg::*;

  typedef enum logic [1:0] {ESC_TEXT, ESC_SEEN, ESC_CSI} esc_mode_t;
  typedef enum logic [1:0] {PH_IDLE, PH_PRINT, PH_TAB, PH_BS} phase_t;

  logic [7:0] text_columns;
  logic [7:0] text_rows;

  phase_t                 phase, phase_next;
  esc_mode_t              esc_mode, esc_mode_next;
  logic [ESC_NUM_W-1:0]   esc_num, esc_num_next;
  logic [2:0]             fore, fore_next;
  logic [2:0]             back, back_next;
  logic [7:0]             col, col_next;
  logic [7:0]             line, line_next;
  logic                   shown, shown_next;
  logic [BLINK_W-1:0]     blink, blink_next;
  logic [2:0]             tab_left, tab_left_next;
  logic [7:0]             glyph_hold, glyph_hold_next;

  logic       out_valid;
  logic [1:0] out_cmd;
  logic [7:0] out_glyph;
  logic [7:0] out_col;
  logic [7:0] out_row;
  logic [2:0] out_fore;
  logic [2:0] out_back;
  logic       out_last;

  logic       em_valid;
  logic [1:0] em_cmd;
  logic [7:0] em_glyph;
  logic [7:0] em_col;
  logic [7:0] em_row;
  logic       em_last;

  logic       out_can;
  logic [7:0] cols_eff;
  logic [7:0] rows_last;
  logic       nl_scroll;
  logic [7:0] nl_line;
  logic       wrap;
  logic [7:0] col_s;
  logic [7:0] line_s;
  logic       scroll_s;
  logic [2:0] tab_n;
  logic       tab_end_s;
  logic       tab_end;
  logic       bs_up;
  logic [7:0] col2;
  logic [7:0] line2;
  logic       bs_second;
  logic [BLINK_W-1:0] blink_inc;
  logic [13:0]          esc_prod;
  logic [ESC_NUM_W-1:0] esc_fg_off;
  logic [ESC_NUM_W-1:0] esc_bg_off;
  logic       is_char;

  assign out_can   = !out_valid || cmd_chan.ready;
  assign cols_eff  = (text_columns == '0) ? 8'd1 : text_columns;
  assign rows_last = (text_rows == '0) ? 8'd0 : text_rows - 8'd1;

  // new line from the current position
  assign nl_scroll = !(line < rows_last);
  assign nl_line   = nl_scroll ? rows_last : line + 8'd1;

  // wrap first when the cursor sits past the last column
  assign wrap     = (col >= cols_eff);
  assign col_s    = wrap ? 8'd0 : col;
  assign line_s   = wrap ? nl_line : line;
  assign scroll_s = wrap && nl_scroll;

  assign tab_n     = 3'(TAB_STOP) - {1'b0, col_s[1:0]};
  assign tab_end_s = (tab_n == 3'd1) || (({1'b0, col_s} + 9'd1) >= {1'b0, cols_eff});
  assign tab_end   = (tab_left == 3'd1) || (({1'b0, col} + 9'd1) >= {1'b0, cols_eff});

  assign bs_up     = (col == '0) && (line != '0);
  assign col2      = bs_up ? cols_eff : col;
  assign line2     = bs_up ? line - 8'd1 : line;
  assign bs_second = (col2 != '0);

  assign blink_inc = blink + BLINK_W'(1);

  // digit character codes carry their value in the low nibble
  assign esc_prod   = {1'b0, esc_num, 3'b000} + {3'b000, esc_num, 1'b0}
                    + {10'd0, q_op.code[3:0]};
  assign esc_fg_off = esc_num - ESC_NUM_W'(SGR_FG_LO);
  assign esc_bg_off = esc_num - ESC_NUM_W'(SGR_BG_LO);

  assign is_char = (q_op.kind != OP_BLINK) && (q_op.kind != OP_CLEAR);

  always_comb begin
    phase_next      = phase;
    esc_mode_next   = esc_mode;
    esc_num_next    = esc_num;
    fore_next       = fore;
    back_next       = back;
    col_next        = col;
    line_next       = line;
    shown_next      = shown;
    blink_next      = blink;
    tab_left_next   = tab_left;
    glyph_hold_next = glyph_hold;
    q_pop           = 1'b0;
    em_valid        = 1'b0;
    em_cmd          = CMD_DRAW;
    em_glyph        = CH_SPACE;
    em_col          = col;
    em_row          = line;
    em_last         = 1'b1;

    if (phase != PH_IDLE) begin
      if (out_can) begin
        em_valid = 1'b1;
        unique case (phase)
          PH_PRINT: begin
            em_glyph   = glyph_hold;
            col_next   = col + 8'd1;
            phase_next = PH_IDLE;
          end
          PH_TAB: begin
            em_last       = tab_end;
            col_next      = col + 8'd1;
            tab_left_next = tab_left - 3'd1;
            phase_next    = tab_end ? PH_IDLE : PH_TAB;
          end
          PH_BS: begin
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end else if (q_valid && out_can) begin
      q_pop = 1'b1;
      priority if (is_char && (esc_mode != ESC_TEXT)) begin
        // swallow escape bytes
        priority if (esc_mode == ESC_SEEN && q_op.code == CH_LBRACKET) begin
          esc_mode_next = ESC_CSI;
          esc_num_next  = '0;
        end else if (esc_mode == ESC_CSI && q_op.code >= CH_ZERO
                     && q_op.code <= CH_NINE) begin
          esc_num_next = (esc_prod > 14'(ESC_NUM_MAX)) ? ESC_NUM_W'(ESC_NUM_MAX)
                                                        : esc_prod[ESC_NUM_W-1:0];
        end else begin
          esc_mode_next = ESC_TEXT;
          if (esc_mode == ESC_CSI && q_op.code == CH_M) begin
            // other numbers leave the colors alone
            if (esc_num == '0) begin
              fore_next = FORE_RESET;
              back_next = BACK_RESET;
            end else if (esc_num >= ESC_NUM_W'(SGR_FG_LO)
                         && esc_num <= ESC_NUM_W'(SGR_FG_HI)) begin
              fore_next = esc_fg_off[2:0];
            end else if (esc_num >= ESC_NUM_W'(SGR_BG_LO)
                         && esc_num <= ESC_NUM_W'(SGR_BG_HI)) begin
              back_next = esc_bg_off[2:0];
            end
          end
        end
      end else begin
        unique case (q_op.kind)
          OP_ESC: begin
            esc_mode_next = ESC_SEEN;
          end
          OP_LF: begin
            col_next  = '0;
            line_next = nl_line;
            if (nl_scroll) begin
              em_valid = 1'b1;
              em_cmd   = CMD_SCROLL;
              em_glyph = '0;
              em_col   = '0;
              em_row   = rows_last;
            end
          end
          OP_CR: begin
            col_next = '0;
          end
          OP_BS: begin
            line_next = line2;
            col_next  = bs_second ? col2 - 8'd1 : col2;
            if (shown) begin
              // redraw the cursor cell, then the step-back cell
              em_valid = 1'b1;
              em_last  = !bs_second;
              if (bs_second) begin
                phase_next = PH_BS;
              end
            end else if (bs_second) begin
              em_valid = 1'b1;
              em_col   = col2 - 8'd1;
              em_row   = line2;
            end
          end
          OP_TAB: begin
            em_valid = 1'b1;
            if (scroll_s) begin
              em_cmd        = CMD_SCROLL;
              em_glyph      = '0;
              em_col        = '0;
              em_row        = rows_last;
              em_last       = 1'b0;
              col_next      = '0;
              line_next     = rows_last;
              tab_left_next = 3'(TAB_STOP);
              phase_next    = PH_TAB;
            end else begin
              em_col        = col_s;
              em_row        = line_s;
              em_last       = tab_end_s;
              col_next      = col_s + 8'd1;
              line_next     = line_s;
              tab_left_next = tab_n - 3'd1;
              phase_next    = tab_end_s ? PH_IDLE : PH_TAB;
            end
          end
          OP_TEXT: begin
            em_valid = 1'b1;
            if (scroll_s) begin
              em_cmd          = CMD_SCROLL;
              em_glyph        = '0;
              em_col          = '0;
              em_row          = rows_last;
              em_last         = 1'b0;
              col_next        = '0;
              line_next       = rows_last;
              glyph_hold_next = q_op.code;
              phase_next      = PH_PRINT;
            end else begin
              em_glyph  = q_op.code;
              em_col    = col_s;
              em_row    = line_s;
              col_next  = col_s + 8'd1;
              line_next = line_s;
            end
          end
          OP_BLINK: begin
            if (blink_inc >= BLINK_W'(BLINK_TICKS)) begin
              blink_next = '0;
              em_valid   = 1'b1;
              shown_next = !shown;
              if (shown) begin
                em_cmd   = CMD_FILL;
                em_glyph = '0;
              end else begin
                em_glyph = CH_UNDERSCORE;
              end
            end else begin
              blink_next = blink_inc;
            end
          end
          OP_CLEAR: begin
            col_next  = '0;
            line_next = '0;
            em_valid  = 1'b1;
            em_cmd    = CMD_CLEAR;
            em_glyph  = '0;
            em_col    = '0;
            em_row    = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= COLUMNS_RESET;
      text_rows    <= ROWS_RESET;
      phase        <= PH_IDLE;
      esc_mode     <= ESC_TEXT;
      esc_num      <= '0;
      fore         <= FORE_RESET;
      back         <= BACK_RESET;
      col          <= '0;
      line         <= '0;
      shown        <= 1'b0;
      blink        <= '0;
      tab_left     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: text_columns <= cfg_data;
          CFG_ROWS:    text_rows    <= cfg_data;
        endcase
      end
      phase    <= phase_next;
      esc_mode <= esc_mode_next;
      esc_num  <= esc_num_next;
      fore     <= fore_next;
      back     <= back_next;
      col      <= col_next;
      line     <= line_next;
      shown    <= shown_next;
      blink    <= blink_next;
      tab_left <= tab_left_next;
      if (out_can) begin
        out_valid <= em_valid;
      end
    end
    glyph_hold <= glyph_hold_next;
    if (out_can && em_valid) begin
      out_cmd   <= em_cmd;
      out_glyph <= em_glyph;
      out_col   <= em_col;
      out_row   <= em_row;
      out_fore  <= fore;
      out_back  <= back;
      out_last  <= em_last;
    end
  end

  assign cmd_chan.valid       = out_valid;
  assign cmd_chan.command     = out_cmd;
  assign cmd_chan.glyph       = out_glyph;
  assign cmd_chan.cell_col    = out_col;
  assign cmd_chan.cell_row    = out_row;
  assign cmd_chan.fore_index  = out_fore;
  assign cmd_chan.back_index  = out_back;
  assign cmd_chan.last_of_run = out_last;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (phase == PH_IDLE))
    else $error("op taken while a run is in progress");
  a_tab_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAB) |-> (tab_left != '0 && tab_left <= 3'(TAB_STOP)))
    else $error("tab run with no cells left");
  a_run_emits: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE && out_can) |=> out_valid)
    else $error("run step gave no command");
  a_clear_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_cmd == CMD_CLEAR) |-> (out_last && out_col == '0 && out_row == '0))
    else $error("clear command malformed");
`endif

endmodule
`default_nettype wire

@@ sv/ansi_text_console_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted item goes through the op queue and the registered output stage.
// Throughput: one item per cycle while each gives at most one command and the
// output does not stall; an item with several commands holds the executor until
// its last is sent (a tab gives up to 5); the 4-entry op queue buffers input.
// Reset: synchronous; cursor, colors, parser, blink and geometry go to their
// reset values, the queue and the output stage empty. No clearing pass.
// ----------------------------------------------------------------------------
// ansi_text_console_engine_top
// Text console: byte classifier and op queue feeding a command executor.
// ----------------------------------------------------------------------------
module ansi_text_console_engine_top #(
  parameter int BLINK_TICKS = atc_pkg::BLINK_TICKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  atc_req_if.sink                              req_chan,
  atc_cmd_if.source                            cmd_chan,
  input  wire logic                            cfg_we,
  input  wire logic [atc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [atc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import atc_pkg::*;

  op_t  q_op;
  logic q_valid;
  logic q_pop;

  atc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_chan (req_chan),
    .q_op     (q_op),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  atc_back #(
    .BLINK_TICKS (BLINK_TICKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_op      (q_op),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cmd_chan  (cmd_chan)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives characters, blink ticks and clear requests into the text console,
// predicts the cell commands from a cursor, color and escape-parser model kept
// here, and compares every command taken from the output channel in order.
// ----------------------------------------------------------------------------
module tb;
  import atc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_LIMIT = 12;
  localparam int WATCHDOG_NS  = 3_000_000;
  localparam int REPORT_MAX   = 10;
  localparam int RUN_MAX      = 5;

  // escape parser states of the model
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] glyph;
    logic [7:0] col;
    logic [7:0] row;
    logic [2:0] fore;
    logic [2:0] back;
    logic       last;
  } cell_cmd_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  atc_req_if req_chan ();
  atc_cmd_if cmd_chan ();

  ansi_text_console_engine_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_chan (req_chan),
    .cmd_chan (cmd_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // console state as the model sees it
  logic [7:0] geo_cols;
  logic [7:0] geo_rows;
  logic [1:0] esc_state;
  int         esc_value;
  logic [2:0] fg_now;
  logic [2:0] bg_now;
  int         cur_col;
  int         cur_row;
  bit         cursor_on;
  int         blink_cnt;

  cell_cmd_t  due_cmds[$];
  cell_cmd_t  run_buf[RUN_MAX];
  int         run_len;

  int         idle_pct;
  int         stall_pct;
  int         items_sent;
  int         mismatches;

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- model ---

  function automatic int cols_in_use();
    return (geo_cols == 8'd0) ? 1 : int'(geo_cols);
  endfunction

  function automatic int rows_in_use();
    return (geo_rows == 8'd0) ? 1 : int'(geo_rows);
  endfunction

  function automatic void add_cmd(input logic [1:0] cmd, input logic [7:0] glyph,
                                  input int col, input int row);
    cell_cmd_t c;
    if (run_len < RUN_MAX) begin
      c.command = cmd;
      c.glyph   = glyph;
      c.col     = 8'(col);
      c.row     = 8'(row);
      c.fore    = fg_now;
      c.back    = bg_now;
      c.last    = 1'b0;
      run_buf[run_len] = c;
      run_len++;
    end
  endfunction

  function automatic void line_feed();
    int bottom;
    bottom  = rows_in_use() - 1;
    cur_col = 0;
    if (cur_row < bottom) begin
      cur_row++;
    end else begin
      cur_row = bottom;
      add_cmd(CMD_SCROLL, 8'd0, 0, bottom);
    end
  endfunction

  function automatic void parse_escape(input logic [7:0] code);
    int v;
    if (esc_state == ESC_SEEN && code == CH_LBRACKET) begin
      esc_state = ESC_CSI;
      esc_value = 0;
    end else if (esc_state == ESC_CSI && code >= CH_ZERO && code <= CH_NINE) begin
      v = esc_value * 10 + (int'(code) - int'(CH_ZERO));
      esc_value = (v > ESC_NUM_MAX) ? ESC_NUM_MAX : v;
    end else begin
      if (esc_state == ESC_CSI && code == CH_M) begin
        if (esc_value == 0) begin
          fg_now = FORE_RESET;
          bg_now = BACK_RESET;
        end else if (esc_value >= SGR_FG_LO && esc_value <= SGR_FG_HI) begin
          fg_now = 3'(esc_value - SGR_FG_LO);
        end else if (esc_value >= SGR_BG_LO && esc_value <= SGR_BG_HI) begin
          bg_now = 3'(esc_value - SGR_BG_LO);
        end
      end
      esc_state = ESC_IDLE;
    end
  endfunction

  function automatic void take_char(input logic [7:0] code);
    int cols;
    int n;
    cols = cols_in_use();
    if (esc_state != ESC_IDLE) begin
      parse_escape(code);
    end else if (code == CH_ESC) begin
      esc_state = ESC_SEEN;
    end else if (code == CH_LF) begin
      line_feed();
    end else if (code == CH_CR) begin
      cur_col = 0;
    end else if (code == CH_BS) begin
      if (cursor_on) add_cmd(CMD_DRAW, CH_SPACE, cur_col, cur_row);
      // reverse wrap onto the end of the previous row
      if (cur_col == 0 && cur_row != 0) begin
        cur_row--;
        cur_col = cols;
      end
      if (cur_col > 0) begin
        cur_col--;
        add_cmd(CMD_DRAW, CH_SPACE, cur_col, cur_row);
      end
    end else if (code == CH_TAB) begin
      if (cur_col >= cols) line_feed();
      n = TAB_STOP - (cur_col % TAB_STOP);
      while (n > 0 && cur_col < cols) begin
        add_cmd(CMD_DRAW, CH_SPACE, cur_col, cur_row);
        cur_col++;
        n--;
      end
    end else begin
      if (cur_col >= cols) line_feed();
      add_cmd(CMD_DRAW, code, cur_col, cur_row);
      cur_col++;
    end
  endfunction

  function automatic void take_blink();
    blink_cnt = (blink_cnt + 1) % 64;
    if (blink_cnt >= BLINK_TICKS_DEF) begin
      blink_cnt = 0;
      if (cursor_on) begin
        add_cmd(CMD_FILL, 8'd0, cur_col, cur_row);
        cursor_on = 1'b0;
      end else begin
        add_cmd(CMD_DRAW, CH_UNDERSCORE, cur_col, cur_row);
        cursor_on = 1'b1;
      end
    end
  endfunction

  function automatic void console_step(input logic [1:0] kind, input logic [7:0] code);
    run_len = 0;
    case (kind)
      REQ_CHAR:  take_char(code);
      REQ_BLINK: take_blink();
      REQ_CLEAR: begin
        cur_col = 0;
        cur_row = 0;
        add_cmd(CMD_CLEAR, 8'd0, 0, 0);
      end
      default: ;
    endcase
    for (int i = 0; i < run_len; i++) begin
      if (i == run_len - 1) run_buf[i].last = 1'b1;
      due_cmds.push_back(run_buf[i]);
    end
  endfunction

  // ---------------------------------------------------------------- check ---

  task automatic report_mismatch(input string what, input cell_cmd_t want,
                                 input cell_cmd_t got);
    if (mismatches < REPORT_MAX) begin
      $display("%0t: %s: want cmd %0d glyph %02h col %0d row %0d fg %0d bg %0d last %0d",
               $realtime, what, want.command, want.glyph, want.col, want.row,
               want.fore, want.back, want.last);
      $display("%0t: %s:  got cmd %0d glyph %02h col %0d row %0d fg %0d bg %0d last %0d",
               $realtime, what, got.command, got.glyph, got.col, got.row,
               got.fore, got.back, got.last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : check_cmds
    cell_cmd_t got;
    cell_cmd_t want;
    if (!rst && cmd_chan.valid === 1'b1 && cmd_chan.ready === 1'b1) begin
      got.command = cmd_chan.command;
      got.glyph   = cmd_chan.glyph;
      got.col     = cmd_chan.cell_col;
      got.row     = cmd_chan.cell_row;
      got.fore    = cmd_chan.fore_index;
      got.back    = cmd_chan.back_index;
      got.last    = cmd_chan.last_of_run;
      if (due_cmds.size() == 0) begin
        want = '0;
        report_mismatch("command with none due", want, got);
      end else begin
        want = due_cmds.pop_front();
        if (got.command !== want.command || got.glyph !== want.glyph ||
            got.col !== want.col || got.row !== want.row ||
            got.fore !== want.fore || got.back !== want.back ||
            got.last !== want.last) begin
          report_mismatch("command mismatch", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    cmd_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ------------------------------------------------------------- stimulus ---

  task automatic send_req(input logic [1:0] kind, input logic [7:0] code);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_chan.valid <= 1'b0;
      @(negedge clk);
    end
    req_chan.valid     <= 1'b1;
    req_chan.req_type  <= kind;
    req_chan.char_code <= code;
    @(posedge clk);
    while (req_chan.ready !== 1'b1) @(posedge clk);
    console_step(kind, code);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] code);
    send_req(REQ_CHAR, code);
  endtask

  // drop valid, wait out every due command and whatever is still queued inside
  task automatic settle();
    @(negedge clk);
    req_chan.valid <= 1'b0;
    while (due_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_LIMIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_COLUMNS) geo_cols = value;
    else geo_rows = value;
  endtask

  task automatic set_geometry(input int cols, input int rows);
    settle();
    write_reg(CFG_COLUMNS, 8'(cols));
    write_reg(CFG_ROWS, 8'(rows));
  endtask

  // ESC [ digits m, with the number drawn from the color ranges or beyond
  task automatic send_sgr();
    int n;
    int v;
    int digs[$];
    bit bare;
    bare = 1'b0;
    case ($urandom_range(5))
      0: begin
        n    = 0;
        bare = 1'b1;
      end
      1: n = $urandom_range(SGR_FG_HI, SGR_FG_LO);
      2: n = $urandom_range(SGR_BG_HI, SGR_BG_LO);
      3: n = $urandom_range(99);
      4: n = $urandom_range(99999, 1000);
      default: n = 0;
    endcase
    v = n;
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    if ($urandom_range(3) == 0) digs.push_front(0);
    send_char(CH_ESC);
    send_char(CH_LBRACKET);
    if (!bare) begin
      foreach (digs[i]) send_char(CH_ZERO + 8'(digs[i]));
    end
    send_char(CH_M);
  endtask

  task automatic random_step();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 24) begin
      send_char(8'($urandom_range(255)));
    end else if (pick < 40) begin
      len = $urandom_range(10, 1);
      repeat (len) send_char(8'($urandom_range(8'h7E, 8'h21)));
    end else if (pick < 48) begin
      send_char(CH_LF);
    end else if (pick < 52) begin
      send_char(CH_CR);
    end else if (pick < 60) begin
      send_char(CH_BS);
    end else if (pick < 67) begin
      send_char(CH_TAB);
    end else if (pick < 80) begin
      send_sgr();
    end else if (pick < 84) begin
      // broken sequence: ESC or ESC [ then an arbitrary byte
      send_char(CH_ESC);
      if ($urandom_range(1)) send_char(CH_LBRACKET);
      send_char(8'($urandom_range(255)));
    end else if (pick < 87) begin
      len = $urandom_range(50, 10);
      repeat (len) send_req(REQ_BLINK, 8'($urandom_range(255)));
    end else if (pick < 92) begin
      send_req(REQ_BLINK, 8'($urandom_range(255)));
    end else if (pick < 95) begin
      send_req(REQ_CLEAR, 8'($urandom_range(255)));
    end else if (pick < 98) begin
      send_req(REQ_NONE, 8'($urandom_range(255)));
    end else begin
      settle();
    end
  endtask

  task automatic run_phase(input int cols, input int rows, input int idle,
                           input int stall, input int count);
    int target;
    set_geometry(cols, rows);
    idle_pct  = idle;
    stall_pct = stall;
    target    = items_sent + count;
    while (items_sent < target) random_step();
  endtask

  // ----------------------------------------------------------------- tests ---

  task automatic test_printable();
    send_char(8'h41);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_TAB);
  endtask

  task automatic test_line_controls();
    send_char(CH_LF);
    send_char(CH_BS);
    send_char(CH_CR);
    // column 0 of row 0: there is no row above to back up onto
    send_char(CH_BS);
  endtask

  task automatic test_color_escapes();
    send_char(CH_ESC);
    send_char(CH_LBRACKET);
    send_char(CH_ZERO + 8'd3);
    send_char(CH_ZERO + 8'd4);
    send_char(CH_M);
    send_char(8'h78);
    send_char(CH_ESC);
    send_char(8'h71);
    send_char(CH_ESC);
    send_char(CH_LBRACKET);
    send_char(CH_M);
    send_char(8'h79);
  endtask

  task automatic test_clear_and_ignore();
    send_req(REQ_CLEAR, 8'h00);
    send_req(REQ_NONE, 8'hA5);
  endtask

  task automatic test_random_traffic();
    run_phase(4, 3, 0, 0, 60);
    run_phase(255, 255, 49, 0, 60);
    run_phase(1, 1, 0, 49, 60);
    run_phase(0, 0, 38, 38, 60);
    run_phase($urandom_range(12, 1), $urandom_range(6, 1), 0, 0, 60);
    run_phase(COLUMNS_RESET, ROWS_RESET, 38, 38, 60);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_COLUMNS;
    cfg_data           = 8'd0;
    req_chan.valid     = 1'b0;
    req_chan.req_type  = REQ_CHAR;
    req_chan.char_code = 8'd0;
    cmd_chan.ready     = 1'b0;
    geo_cols           = COLUMNS_RESET;
    geo_rows           = ROWS_RESET;
    esc_state          = ESC_IDLE;
    esc_value          = 0;
    fg_now             = FORE_RESET;
    bg_now             = BACK_RESET;
    cur_col            = 0;
    cur_row            = 0;
    cursor_on          = 1'b0;
    blink_cnt          = 0;
    idle_pct           = 0;
    stall_pct          = 0;
    items_sent         = 0;
    mismatches         = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_printable();
    test_line_controls();
    test_color_escapes();
    test_clear_and_ignore();
    test_random_traffic();

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
